// ===== rtl/cpseg_pkg.sv =====
// Types, constants and arithmetic helpers for the segment closest-point pipeline.
package cpseg_pkg;

	localparam int CW = 32;              // coordinate width
	localparam int FB = 16;              // fraction bits
	localparam int VW = CW + 1;          // direction and offset vectors
	localparam int PW = 2 * VW;          // one coordinate product
	localparam int KW = PW + 2;          // dot products a..e
	localparam int HW = KW / 2;          // half of a dot product for split multiplies
	localparam int DW = 2 * KW + 2;      // det and numerators
	localparam int QW = DW;              // divider remainder and divisor
	localparam int TBW = FB + 2 + KW;    // parameter times b
	localparam int MW = FB + 2 + VW;     // parameter times direction
	localparam int THW = 64;             // threshold register
	localparam int SQW = 88;             // |det| bits squared exactly; above this always non-parallel
	localparam int LW = 30;              // limb of the det square
	localparam int DSW = 6 * LW;         // det squared

	typedef struct packed {
		logic signed [CW-1:0] a0_x;
		logic signed [CW-1:0] a0_y;
		logic signed [CW-1:0] a0_z;
		logic signed [CW-1:0] a1_x;
		logic signed [CW-1:0] a1_y;
		logic signed [CW-1:0] a1_z;
		logic signed [CW-1:0] b0_x;
		logic signed [CW-1:0] b0_y;
		logic signed [CW-1:0] b0_z;
		logic signed [CW-1:0] b1_x;
		logic signed [CW-1:0] b1_y;
		logic signed [CW-1:0] b1_z;
	} pt_in_t;

	typedef struct packed {
		logic signed [CW-1:0] near_a_x;
		logic signed [CW-1:0] near_a_y;
		logic signed [CW-1:0] near_a_z;
		logic signed [CW-1:0] near_b_x;
		logic signed [CW-1:0] near_b_y;
		logic signed [CW-1:0] near_b_z;
	} pt_out_t;

	// geometry carried along the pipe
	typedef struct packed {
		logic [2:0][CW-1:0] pa0;
		logic [2:0][CW-1:0] pb0;
		logic [2:0][VW-1:0] v1;
		logic [2:0][VW-1:0] v2;
		logic signed [KW-1:0] a;
		logic signed [KW-1:0] b;
		logic signed [KW-1:0] c;
		logic signed [KW-1:0] d;
		logic signed [KW-1:0] e;
		logic [FB:0] t;
	} ctx_t;

	// long-division state; byp means the answer was settled up front
	typedef struct packed {
		logic byp;
		logic [FB:0] bval;
		logic [FB-1:0] q;
		logic [QW-1:0] rem;
		logic [QW-1:0] den;
	} qdiv_t;

	// partial products of a KW x KW signed multiply, signed high half, unsigned low half
	typedef struct packed {
		logic signed [2*HW-1:0] hh;
		logic signed [2*HW:0]   hl;
		logic signed [2*HW:0]   lh;
		logic [2*HW-1:0]        ll;
	} pp_t;

	localparam logic [FB:0] Q_ONE = {1'b1, {FB{1'b0}}};

	function automatic qdiv_t qzero();
		qdiv_t r;
		r = '0;
		r.byp = 1'b1;
		return r;
	endfunction

	// floor(clamp(num/den, 0, 1) * 2^FB) setup; zero divisor gives 0
	function automatic qdiv_t qprep(input logic signed [DW-1:0] num,
			input logic signed [DW-1:0] den);
		logic signed [DW-1:0] nn;
		logic signed [DW-1:0] dd;
		qdiv_t r;
		nn = (den < 0) ? -num : num;
		dd = (den < 0) ? -den : den;
		r = '0;
		if (dd == '0) begin
			r.byp = 1'b1;
		end else if (nn <= 0) begin
			r.byp = 1'b1;
		end else if (nn >= dd) begin
			r.byp = 1'b1;
			r.bval = Q_ONE;
		end else begin
			r.rem = nn;
			r.den = dd;
		end
		return r;
	endfunction

	function automatic qdiv_t qstep(input qdiv_t x);
		logic [QW:0] r2;
		qdiv_t r;
		r = x;
		r2 = {x.rem, 1'b0};
		if (!x.byp) begin
			if (r2 >= {1'b0, x.den}) begin
				r2 = r2 - {1'b0, x.den};
				r.q = {x.q[FB-2:0], 1'b1};
			end else begin
				r.q = {x.q[FB-2:0], 1'b0};
			end
			r.rem = r2[QW-1:0];
		end
		return r;
	endfunction

	function automatic logic [FB:0] qres(input qdiv_t x);
		return x.byp ? x.bval : {1'b0, x.q};
	endfunction

	function automatic pp_t pmul(input logic signed [KW-1:0] x,
			input logic signed [KW-1:0] y);
		pp_t r;
		r.hh = $signed(x[KW-1:HW]) * $signed(y[KW-1:HW]);
		r.hl = $signed(x[KW-1:HW]) * $signed({1'b0, y[HW-1:0]});
		r.lh = $signed({1'b0, x[HW-1:0]}) * $signed(y[KW-1:HW]);
		r.ll = x[HW-1:0] * y[HW-1:0];
		return r;
	endfunction

	// full product from its partials, modulo 2^(2*KW)
	function automatic logic signed [2*KW-1:0] psum(input pp_t p);
		logic signed [2*KW-1:0] mid;
		mid = (2*KW)'(p.hl) + (2*KW)'(p.lh);
		return ((2*KW)'(p.hh) <<< (2*HW)) + (mid <<< HW) + (2*KW)'(p.ll);
	endfunction

	// base + round_half_up(m / 2^FB), saturated to the coordinate range
	function automatic logic [CW-1:0] place(input logic signed [CW-1:0] base,
			input logic signed [MW-1:0] m);
		logic signed [MW+1:0] acc;
		logic signed [MW+1:0] cmax;
		logic signed [MW+1:0] cmin;
		logic signed [MW+1:0] half;
		cmax = (MW+2)'({1'b0, {(CW-1){1'b1}}});
		cmin = -cmax - (MW+2)'(1);
		half = (MW+2)'({1'b1, {(FB-1){1'b0}}});
		acc = (MW+2)'(m) + half;
		acc = (acc >>> FB) + (MW+2)'(base);
		if (acc > cmax) acc = cmax;
		if (acc < cmin) acc = cmin;
		return acc[CW-1:0];
	endfunction

endpackage

// ===== rtl/closest_points_two_segments_top.sv =====
// Closest points between two 3D segments: fully pipelined datapath.
// Throughput: one segment pair per cycle; each stage advances when the next has room,
// so bubbles collapse and a stalled output does not block upstream until the pipe fills.
// The three clamped quotients each take FB restoring-division stages, which set depth.
// Reset clears all stage valid bits and loads the parallel threshold with 1.
module closest_points_two_segments_top import cpseg_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [THW-1:0] cfg_wdata,
	input  logic           pt_valid,
	output logic           pt_ready,
	input  pt_in_t         pt_data,
	output logic           res_valid,
	input  logic           res_ready,
	output pt_out_t        res_data
);

	localparam int PRE = 10;
	localparam int C0  = PRE;
	localparam int T1  = C0 + FB;
	localparam int T2  = T1 + 1;
	localparam int C1  = T2 + 1;
	localparam int U1  = C1 + FB;
	localparam int U2  = U1 + 1;
	localparam int C2  = U2 + 1;
	localparam int P1  = C2 + FB;
	localparam int P2  = P1 + 1;
	localparam int NS  = P2 + 1;

	logic [NS-1:0] vld;
	logic [NS-1:0] take;
	logic [THW-1:0] thr_q;

	// ready ripples back: a stage loads when empty or when its successor loads
	always_comb begin
		take[NS-1] = ~vld[NS-1] | res_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			take[i] = ~vld[i] | take[i+1];
		end
	end

	assign pt_ready = take[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (take[0]) vld[0] <= pt_valid;
			for (int i = 1; i < NS; i++) begin
				if (take[i]) vld[i] <= vld[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THW'(1);
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// input word unpack
	logic signed [CW-1:0] ia0 [3];
	logic signed [CW-1:0] ia1 [3];
	logic signed [CW-1:0] ib0 [3];
	logic signed [CW-1:0] ib1 [3];
	assign ia0[0] = pt_data.a0_x;
	assign ia0[1] = pt_data.a0_y;
	assign ia0[2] = pt_data.a0_z;
	assign ia1[0] = pt_data.a1_x;
	assign ia1[1] = pt_data.a1_y;
	assign ia1[2] = pt_data.a1_z;
	assign ib0[0] = pt_data.b0_x;
	assign ib0[1] = pt_data.b0_y;
	assign ib0[2] = pt_data.b0_z;
	assign ib1[0] = pt_data.b1_x;
	assign ib1[1] = pt_data.b1_y;
	assign ib1[2] = pt_data.b1_z;

	ctx_t c0;
	logic [2:0][VW-1:0] r0;
	always_comb begin
		c0 = '0;
		for (int k = 0; k < 3; k++) begin
			c0.pa0[k] = ia0[k];
			c0.pb0[k] = ib0[k];
			c0.v1[k] = VW'(ia1[k]) - VW'(ia0[k]);
			c0.v2[k] = VW'(ib1[k]) - VW'(ib0[k]);
			r0[k] = VW'(ia0[k]) - VW'(ib0[k]);
		end
	end

	ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	logic [2:0][VW-1:0] r_s1;
	logic signed [PW-1:0] p_s2 [5][3];
	pp_t bbp_s4, acp_s4, cdp_s4, bep_s4;
	logic signed [2*KW-1:0] bb_s5, ac_s5, cd_s5, be_s5;
	logic signed [DW-1:0] det_s6, num_s6;
	logic [DW-2:0] adet_s7;
	logic [5:0][2*LW-1:0] sq_s8;
	logic big_s8, big_s9;
	logic [DSW-1:0] dsq_s9;
	logic [DSW-1:0] thr_ext;
	logic [2:0][LW-1:0] lmb;
	qdiv_t q_s7, q_s8, q_s9, q_s10;
	ctx_t c_s11, c_s12, c_s13, c_s14, c_s15;
	logic signed [TBW-1:0] tb_s11, tb_s13;
	qdiv_t q_s12, q_s14;
	logic [FB:0] s_s15;
	logic signed [MW-1:0] ma_s15 [3];
	logic signed [MW-1:0] mb_s15 [3];
	pt_out_t out_s16;
	pt_out_t out_n;
	ctx_t c3n;

	qdiv_t dq [3][FB];
	ctx_t dc [3][FB];
	qdiv_t fq [3];
	ctx_t fc [3];

	assign thr_ext = DSW'({thr_q, {(7*FB){1'b0}}});

	// |det| below 2^SQW split into limbs for the square
	assign lmb = {LW'(adet_s7[SQW-1:2*LW]), adet_s7[2*LW-1:LW], adet_s7[LW-1:0]};

	logic signed [KW-1:0] sum3 [5];
	always_comb begin
		for (int j = 0; j < 5; j++) begin
			sum3[j] = KW'(p_s2[j][0]) + KW'(p_s2[j][1]) + KW'(p_s2[j][2]);
		end
		c3n = c_s2;
		c3n.a = sum3[0];
		c3n.b = sum3[1];
		c3n.c = sum3[2];
		c3n.d = sum3[3];
		c3n.e = sum3[4];
	end

	logic [FB:0] s0_q, t_q, s_q;
	ctx_t ct_u, cp_p;
	always_comb begin
		s0_q = qres(dq[0][FB-1]);
		t_q = qres(dq[1][FB-1]);
		s_q = qres(dq[2][FB-1]);
		ct_u = dc[1][FB-1];
		ct_u.t = t_q;
		cp_p = dc[2][FB-1];
	end

	always_comb begin
		out_n.near_a_x = place($signed(c_s15.pa0[0]), ma_s15[0]);
		out_n.near_a_y = place($signed(c_s15.pa0[1]), ma_s15[1]);
		out_n.near_a_z = place($signed(c_s15.pa0[2]), ma_s15[2]);
		out_n.near_b_x = place($signed(c_s15.pb0[0]), mb_s15[0]);
		out_n.near_b_y = place($signed(c_s15.pb0[1]), mb_s15[1]);
		out_n.near_b_z = place($signed(c_s15.pb0[2]), mb_s15[2]);
	end

	always_ff @(posedge clk) begin
		if (take[0]) begin
			c_s1 <= c0;
			r_s1 <= r0;
		end
		if (take[1]) begin
			c_s2 <= c_s1;
			for (int k = 0; k < 3; k++) begin
				p_s2[0][k] <= $signed(c_s1.v1[k]) * $signed(c_s1.v1[k]);
				p_s2[1][k] <= $signed(c_s1.v1[k]) * $signed(c_s1.v2[k]);
				p_s2[2][k] <= $signed(c_s1.v2[k]) * $signed(c_s1.v2[k]);
				p_s2[3][k] <= $signed(c_s1.v1[k]) * $signed(r_s1[k]);
				p_s2[4][k] <= $signed(c_s1.v2[k]) * $signed(r_s1[k]);
			end
		end
		if (take[2]) begin
			c_s3 <= c3n;
		end
		if (take[3]) begin
			c_s4 <= c_s3;
			bbp_s4 <= pmul(c_s3.b, c_s3.b);
			acp_s4 <= pmul(c_s3.a, c_s3.c);
			cdp_s4 <= pmul(c_s3.c, c_s3.d);
			bep_s4 <= pmul(c_s3.b, c_s3.e);
		end
		if (take[4]) begin
			c_s5 <= c_s4;
			bb_s5 <= psum(bbp_s4);
			ac_s5 <= psum(acp_s4);
			cd_s5 <= psum(cdp_s4);
			be_s5 <= psum(bep_s4);
		end
		if (take[5]) begin
			c_s6 <= c_s5;
			det_s6 <= DW'(bb_s5) - DW'(ac_s5);
			num_s6 <= DW'(cd_s5) - DW'(be_s5);
		end
		if (take[6]) begin
			c_s7 <= c_s6;
			q_s7 <= qprep(num_s6, det_s6);
			adet_s7 <= (det_s6 < 0) ? (DW-1)'(-det_s6) : (DW-1)'(det_s6);
		end
		if (take[7]) begin
			c_s8 <= c_s7;
			q_s8 <= q_s7;
			big_s8 <= |adet_s7[DW-2:SQW];
			sq_s8[0] <= lmb[0] * lmb[0];
			sq_s8[1] <= lmb[1] * lmb[1];
			sq_s8[2] <= lmb[2] * lmb[2];
			sq_s8[3] <= lmb[0] * lmb[1];
			sq_s8[4] <= lmb[0] * lmb[2];
			sq_s8[5] <= lmb[1] * lmb[2];
		end
		if (take[8]) begin
			c_s9 <= c_s8;
			q_s9 <= q_s8;
			big_s9 <= big_s8;
			dsq_s9 <= DSW'(sq_s8[0]) + (DSW'(sq_s8[3]) << (LW + 1))
				+ ((DSW'(sq_s8[1]) + (DSW'(sq_s8[4]) << 1)) << (2 * LW))
				+ (DSW'(sq_s8[5]) << (3 * LW + 1)) + (DSW'(sq_s8[2]) << (4 * LW));
		end
		if (take[9]) begin
			c_s10 <= c_s9;
			// near-parallel: first parameter forced to zero
			q_s10 <= (big_s9 || dsq_s9 > thr_ext) ? q_s9 : qzero();
		end
		if (take[T1]) begin
			c_s11 <= dc[0][FB-1];
			tb_s11 <= $signed({1'b0, s0_q}) * dc[0][FB-1].b;
		end
		if (take[T2]) begin
			c_s12 <= c_s11;
			q_s12 <= qprep(DW'(tb_s11) + DW'($signed({c_s11.e, {FB{1'b0}}})),
				DW'($signed({c_s11.c, {FB{1'b0}}})));
		end
		if (take[U1]) begin
			c_s13 <= ct_u;
			tb_s13 <= $signed({1'b0, t_q}) * ct_u.b;
		end
		if (take[U2]) begin
			c_s14 <= c_s13;
			q_s14 <= qprep(DW'(tb_s13) - DW'($signed({c_s13.d, {FB{1'b0}}})),
				DW'($signed({c_s13.a, {FB{1'b0}}})));
		end
		if (take[P1]) begin
			c_s15 <= cp_p;
			s_s15 <= s_q;
			for (int k = 0; k < 3; k++) begin
				ma_s15[k] <= $signed({1'b0, s_q}) * $signed(cp_p.v1[k]);
				mb_s15[k] <= $signed({1'b0, cp_p.t}) * $signed(cp_p.v2[k]);
			end
		end
		if (take[P2]) begin
			out_s16 <= out_n;
		end
	end

	assign fq[0] = q_s10;
	assign fc[0] = c_s10;
	assign fq[1] = q_s12;
	assign fc[1] = c_s12;
	assign fq[2] = q_s14;
	assign fc[2] = c_s14;

	// one quotient bit per stage
	for (genvar gc = 0; gc < 3; gc++) begin : g_div
		localparam int BASE = (gc == 0) ? C0 : ((gc == 1) ? C1 : C2);
		for (genvar gs = 0; gs < FB; gs++) begin : g_step
			if (gs == 0) begin : g_first
				always_ff @(posedge clk) begin
					if (take[BASE]) begin
						dq[gc][gs] <= qstep(fq[gc]);
						dc[gc][gs] <= fc[gc];
					end
				end
			end else begin : g_next
				always_ff @(posedge clk) begin
					if (take[BASE+gs]) begin
						dq[gc][gs] <= qstep(dq[gc][gs-1]);
						dc[gc][gs] <= dc[gc][gs-1];
					end
				end
			end
		end
	end

	assign res_valid = vld[NS-1];
	assign res_data = out_s16;

	a_thr_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> thr_q == $past(cfg_wdata))
		else $error("threshold register missed a write");

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[P2-1] |-> (s_s15 <= Q_ONE && c_s15.t <= Q_ONE))
		else $error("segment parameter above one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(pt_valid && pt_ready) |=> vld[0])
		else $error("accepted word not captured in first stage");

endmodule
